/* rtl/pse_pkg.sv */
// Shared constants, codes and helper functions of the postfix stack evaluator.
package pse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DIV_CNT_W   = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_DIV  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_DIV,
    S_SIGN,
    S_WB,
    S_FINISH
  } state_t;

  function automatic logic [DATA_WIDTH-1:0] to_data(input logic [31:0] v);
    logic [63:0] e;
    e = 64'(signed'(v));
    return e[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] from_data(input logic [DATA_WIDTH-1:0] v);
    logic [63:0] e;
    e = 64'(signed'(v));
    return e[31:0];
  endfunction

endpackage

/* rtl/pse_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/postfix_stack_evaluator.sv */
// Top level of the postfix stack evaluator: token input, stack memory, ALU and result output.
//
// Each input transaction carries one token: in_tuser holds the token kind (push, add,
// subtract, multiply, divide) and in_tdata the number to push. Every token produces
// exactly one output transaction that reports the top entry, the number of entries
// held and a status code (ok, underflow, overflow, divide by zero).
// The stack lives in a RAM with a registered read; the top entry is also kept in a
// register, so an operator needs only one RAM read, for the entry below the top.
// Push and rejected tokens pass through the decode and finish steps; add, subtract
// and multiply through decode, read, write-back and finish; divide through decode,
// read, divide, sign, write-back and finish, where the restoring divider makes one
// quotient bit per cycle. The next token is accepted only after the result has
// been loaded into the output register.
// One token is processed at a time; in_tready is high only while the block waits
// for a token. The output register lets the next token be accepted and worked on
// while the previous result still waits; if out_tready stays low, the new token
// halts at its last step until the output register is free.
// Reset empties the stack and clears the output valid flag; stack entries are
// never read before they are written.
module postfix_stack_evaluator
  import pse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand_value
  input  logic [2:0]  in_tuser,   // [2:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] top_value, [36:32] stack_depth, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  state_t                state_r, state_nxt;
  logic [2:0]            mode_r, mode_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] top_r, top_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_top_r, out_top_nxt;
  logic [CNT_W-1:0]      out_depth_r, out_depth_nxt;
  logic [1:0]            out_status_r, out_status_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [CNT_W-1:0]      cnt_m2;
  logic [DATA_WIDTH:0]   div_shift;
  logic [DATA_WIDTH:0]   div_diff;

  pse_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cnt_m2    = cnt_r - CNT_W'(2);
  assign div_shift = {rem_r, quo_r[DATA_WIDTH-1]};
  assign div_diff  = div_shift - {1'b0, dvs_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_depth_r, out_top_r};
  assign out_tuser  = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    val_nxt        = val_r;
    cnt_nxt        = cnt_r;
    top_nxt        = top_r;
    status_nxt     = status_r;
    res_nxt        = res_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dvs_nxt        = dvs_r;
    neg_nxt        = neg_r;
    dcnt_nxt       = dcnt_r;
    out_valid_nxt  = out_valid_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[ADDR_W-1:0];
    ram_wdata      = val_r;
    ram_raddr      = cnt_m2[ADDR_W-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser;
          val_nxt   = to_data(in_tdata);
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        status_nxt = ST_OK;
        state_nxt  = S_FINISH;
        case (mode_r)
          MODE_PUSH: begin
            if (cnt_r >= CNT_W'(STACK_DEPTH)) begin
              status_nxt = ST_OVER;
            end else begin
              ram_we  = 1'b1;
              top_nxt = val_r;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
            if (cnt_r < CNT_W'(2)) begin
              status_nxt = ST_UNDER;
            end else if (mode_r == MODE_DIV && top_r == '0) begin
              status_nxt = ST_DIVZ;
            end else begin
              state_nxt = S_READ;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end
      S_READ: begin
        state_nxt = S_WB;
        case (mode_r)
          MODE_ADD: res_nxt = ram_rdata + top_r;
          MODE_SUB: res_nxt = ram_rdata - top_r;
          MODE_MUL: res_nxt = ram_rdata * top_r;
          default: begin
            rem_nxt   = '0;
            quo_nxt   = ram_rdata[DATA_WIDTH-1] ? -ram_rdata : ram_rdata;
            dvs_nxt   = top_r[DATA_WIDTH-1] ? -top_r : top_r;
            neg_nxt   = ram_rdata[DATA_WIDTH-1] ^ top_r[DATA_WIDTH-1];
            dcnt_nxt  = '0;
            state_nxt = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        if (!div_diff[DATA_WIDTH]) begin
          rem_nxt = div_diff[DATA_WIDTH-1:0];
          quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = div_shift[DATA_WIDTH-1:0];
          quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
        if (dcnt_r == DIV_CNT_W'(DATA_WIDTH - 1)) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        res_nxt   = neg_r ? -quo_r : quo_r;
        state_nxt = S_WB;
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m2[ADDR_W-1:0];
        ram_wdata = res_r;
        top_nxt   = res_r;
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_top_nxt    = (cnt_r != '0) ? from_data(top_r) : 32'd0;
          out_depth_nxt  = cnt_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    val_r        <= val_nxt;
    top_r        <= top_nxt;
    status_r     <= status_nxt;
    res_r        <= res_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    dvs_r        <= dvs_nxt;
    neg_r        <= neg_nxt;
    dcnt_r       <= dcnt_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

/* tb/sv/postfix_stack_evaluator_tb.sv */
// Self-checking stream testbench for the postfix stack evaluator with a shadow operand stack.
module postfix_stack_evaluator_tb;
  import pse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 450;
  localparam int TAIL_ITEMS     = 40;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] operand;
  } token_t;

  typedef struct {
    logic [31:0] top_value;
    logic [4:0]  depth;
    status_t     status;
  } stack_report_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  token_t        token_queue[$];
  stack_report_t expected_reports[$];

  logic [DATA_WIDTH-1:0] shadow_stack[STACK_DEPTH];
  int                    shadow_count;

  logic token_taken;
  int   token_gap;
  int   token_calm;
  int   ready_stall;
  int   ready_calm;
  int   idle_cycles;
  int   mismatch_count;
  int   gen_depth;

  postfix_stack_evaluator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [31:0] narrow_to_port(input logic [DATA_WIDTH-1:0] entry);
    logic signed [63:0] wide;
    wide = 64'($signed(entry));
    return wide[31:0];
  endfunction

  task automatic evaluate_token(input logic [2:0] mode, input logic [31:0] operand);
    logic [63:0]           widened;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] r;
    logic signed [63:0]    sa;
    logic signed [63:0]    sb;
    logic signed [63:0]    q;
    logic                  commit;
    stack_report_t         report;
    widened = {{32{operand[31]}}, operand};
    report.status = ST_OK;
    commit = 1'b0;
    r = '0;
    if (mode == MODE_PUSH) begin
      if (shadow_count >= STACK_DEPTH) begin
        report.status = ST_OVER;
      end else begin
        shadow_stack[shadow_count] = widened[DATA_WIDTH-1:0];
        shadow_count++;
      end
    end else if (mode >= MODE_ADD && mode <= MODE_DIV) begin
      if (shadow_count < 2) begin
        report.status = ST_UNDER;
      end else begin
        b = shadow_stack[shadow_count-1];
        a = shadow_stack[shadow_count-2];
        commit = 1'b1;
        case (mode)
          MODE_ADD: begin
            r = a + b;
          end
          MODE_SUB: begin
            r = a - b;
          end
          MODE_MUL: begin
            r = a * b;
          end
          default: begin
            if (b == '0) begin
              report.status = ST_DIVZ;
              commit = 1'b0;
            end else begin
              sa = 64'($signed(a));
              sb = 64'($signed(b));
              q = sa / sb;
              r = q[DATA_WIDTH-1:0];
            end
          end
        endcase
        if (commit) begin
          shadow_stack[shadow_count-2] = r;
          shadow_count--;
        end
      end
    end
    report.top_value = (shadow_count > 0) ? narrow_to_port(shadow_stack[shadow_count-1]) : '0;
    report.depth = 5'(shadow_count);
    expected_reports.push_back(report);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      5, 6: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_token(input logic [2:0] mode, input logic [31:0] operand);
    token_t tok;
    tok.mode = mode;
    tok.operand = operand;
    token_queue.push_back(tok);
    if (mode == MODE_PUSH) begin
      if (gen_depth < STACK_DEPTH) gen_depth++;
    end else if (mode >= MODE_ADD && mode <= MODE_DIV && gen_depth >= 2) begin
      gen_depth--;
    end
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || token_taken) begin
        if (token_gap > 0) begin
          token_gap <= token_gap - 1;
          in_tvalid <= 1'b0;
        end else if (token_queue.size() > 0) begin
          if (token_queue.size() > TAIL_ITEMS && token_calm == 0 &&
              $urandom_range(0, 5) == 0) begin
            in_tvalid <= 1'b0;
            token_gap <= $urandom_range(0, 15);
            token_calm <= $urandom_range(0, 40);
          end else begin
            in_tvalid <= 1'b1;
            in_tuser <= token_queue[0].mode;
            in_tdata <= token_queue[0].operand;
            void'(token_queue.pop_front());
            if (token_calm > 0) token_calm <= token_calm - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (ready_stall > 0) begin
        ready_stall <= ready_stall - 1;
        out_tready <= 1'b0;
      end else if (token_queue.size() > TAIL_ITEMS && ready_calm == 0 &&
                   $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        ready_stall <= $urandom_range(0, 15);
        ready_calm <= $urandom_range(0, 40);
      end else begin
        out_tready <= 1'b1;
        if (ready_calm > 0) ready_calm <= ready_calm - 1;
      end
    end
  end

  always @(posedge clk) begin
    stack_report_t want;
    logic [31:0]   got_top;
    logic [4:0]    got_depth;
    if (rst_n) begin
      token_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) evaluate_token(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got_top = out_tdata[31:0];
        got_depth = out_tdata[36:32];
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result transaction: top %0d depth %0d status %0d",
                     $signed(got_top), got_depth, out_tuser);
        end else begin
          want = expected_reports.pop_front();
          if (got_top !== want.top_value || got_depth !== want.depth ||
              out_tuser !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("result mismatch: expected top %0d depth %0d status %0d,",
                       $signed(want.top_value), want.depth, want.status,
                       " got top %0d depth %0d status %0d",
                       $signed(got_top), got_depth, out_tuser);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_PUSH;
    out_tready = 1'b0;
    rst_n = 1'b0;
    token_taken = 1'b0;
    token_gap = 0;
    token_calm = 0;
    ready_stall = 0;
    ready_calm = 0;
    idle_cycles = 0;
    mismatch_count = 0;
    shadow_count = 0;
    gen_depth = 0;

    // Directed opening: underflow, wrap on add, most negative over minus one,
    // divide by zero, truncation toward zero, spare token kinds.
    queue_token(MODE_ADD, 32'hffff_ffff);
    queue_token(MODE_PUSH, 32'h7fff_ffff);
    queue_token(MODE_DIV, 32'h0000_0000);
    queue_token(MODE_PUSH, 32'h0000_0001);
    queue_token(MODE_ADD, 32'h5555_5555);
    queue_token(MODE_PUSH, 32'hffff_ffff);
    queue_token(MODE_DIV, 32'haaaa_aaaa);
    queue_token(MODE_PUSH, 32'h0000_0000);
    queue_token(MODE_DIV, 32'h0000_0000);
    queue_token(MODE_MUL, 32'hffff_ffff);
    queue_token(MODE_PUSH, 32'hffff_fff9);
    queue_token(MODE_PUSH, 32'h0000_0002);
    queue_token(MODE_DIV, 32'h0000_0000);
    queue_token(MODE_SUB, 32'h0000_0000);
    queue_token(MODE_PUSH, 32'h8000_0000);
    queue_token(MODE_MUL, 32'h0000_0000);
    queue_token(MODE_SPARE_FIRST, 32'h1234_5678);
    queue_token(MODE_SPARE_LAST, 32'hffff_ffff);
    queue_token(MODE_SPARE_MID, 32'h8000_0000);
    queue_token(MODE_SUB, 32'h0000_0000);
    queue_token(MODE_MUL, 32'h0000_0000);

    while (token_queue.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          while (gen_depth < STACK_DEPTH) queue_token(MODE_PUSH, pick_operand());
          repeat ($urandom_range(1, 3)) queue_token(MODE_PUSH, pick_operand());
        end
        1: begin
          while (gen_depth >= 2)
            queue_token(3'($urandom_range(MODE_ADD, MODE_DIV)), $urandom());
          queue_token(3'($urandom_range(MODE_ADD, MODE_DIV)), $urandom());
        end
        2: begin
          repeat ($urandom_range(1, 4))
            queue_token(3'($urandom_range(MODE_PUSH, MODE_SPARE_LAST)), $urandom());
        end
        default: begin
          repeat ($urandom_range(1, 10)) begin
            if (gen_depth < 2 || (gen_depth < STACK_DEPTH && $urandom_range(0, 1) == 0))
              queue_token(MODE_PUSH, pick_operand());
            else
              queue_token(3'($urandom_range(MODE_ADD, MODE_DIV)), $urandom());
          end
        end
      endcase
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (token_queue.size() == 0 && !in_tvalid);
    wait (expected_reports.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pse_pkg.sv
rtl/pse_ram.sv
rtl/postfix_stack_evaluator.sv
tb/sv/postfix_stack_evaluator_tb.sv
